// ===== rtl/pshp_pkg.sv =====
// ----------------------------------------------------------------------------
// pshp_pkg
// Shared types, constants and helpers of the pc sample histogram profiler.
// ----------------------------------------------------------------------------
package pshp_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int ADDR_BITS   = 32;
   localparam int COUNT_BITS  = 32;

   localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
   localparam int PTR_BITS    = IDX_BITS + 1;

   localparam int ENTRY_BITS  = 8;
   localparam int ACTION_BITS = 2;
   localparam int CFG_N_BITS  = 9;
   localparam int CSR_DATA_BITS = 9;
   localparam int CSR_INDEX_BITS = 1;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 72;

   localparam logic [CFG_N_BITS-1:0] ENTRIES_RESET = CFG_N_BITS'(256);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENTRIES = 1'b0,
      CSR_ENABLE  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PROBE,
      ST_CMP,
      ST_CNT_RD,
      ST_CNT_USE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic start_wr;
      logic clear;
      logic search_init;
      logic probe_step;
      logic total_inc;
      logic count_update;
      logic count_take;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       enabled;
      logic       lo_lt_hi;
      logic       lo_nonzero;
   } status_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (v == '1) ? v : v + COUNT_BITS'(1);
      return r;
   endfunction

endpackage

// ===== rtl/pshp_ram.sv =====
// ----------------------------------------------------------------------------
// pshp_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module pshp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pshp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pshp_ctrl
// Sequencer: accepts one transaction, steps the search and counter update,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module pshp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output pshp_pkg::cmd_type    cmd,
   input  pshp_pkg::status_type status
);
   import pshp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.action)
               ACT_LOAD: begin
                  cmd.start_wr = 1'b1;
                  state_in     = ST_FINISH;
               end
               ACT_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_FINISH;
               end
               ACT_SAMPLE: begin
                  if (status.enabled) begin
                     cmd.search_init = 1'b1;
                     state_in        = ST_PROBE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               ACT_READ: begin
                  state_in = ST_CNT_RD;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_PROBE: begin
            if (status.lo_lt_hi) begin
               state_in = ST_CMP;
            end else if (status.lo_nonzero) begin
               state_in = ST_CNT_RD;
            end else begin
               cmd.total_inc = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_CMP: begin
            cmd.probe_step = 1'b1;
            state_in       = ST_PROBE;
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_USE;
         end
         ST_CNT_USE: begin
            if (status.action == ACT_READ) begin
               cmd.count_take = 1'b1;
            end else begin
               cmd.count_update = 1'b1;
               cmd.total_inc    = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/pshp_dp.sv =====
// ----------------------------------------------------------------------------
// pshp_dp
// Datapath: config registers, region start table, bin counters with valid
// bits, binary search bounds, total counter and result register.
// ----------------------------------------------------------------------------
module pshp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [pshp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [pshp_pkg::ACTION_BITS-1:0]     req_tuser,
   input  logic                                 csr_we,
   input  logic [pshp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pshp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  pshp_pkg::cmd_type                    cmd,
   output pshp_pkg::status_type                 status,
   output logic [pshp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tuser
);
   import pshp_pkg::*;

   logic [CFG_N_BITS-1:0]  entries_ff;
   logic                   enable_ff;
   action_type             action_ff;
   logic [ENTRY_BITS-1:0]  idx_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [PTR_BITS-1:0]    lo_ff, lo_in;
   logic [PTR_BITS-1:0]    hi_ff, hi_in;
   logic [COUNT_BITS-1:0]  total_ff, total_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic                   found_ff, found_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic [ENTRY_BITS-1:0]  out_index_ff;
   logic                   out_found_ff;
   logic [COUNT_BITS-1:0]  out_count_ff;
   logic [COUNT_BITS-1:0]  out_total_ff;

   logic [PTR_BITS:0]      bound_sum;
   logic [IDX_BITS-1:0]    mid;
   logic [PTR_BITS-1:0]    limit;
   logic [IDX_BITS-1:0]    region;
   logic [IDX_BITS-1:0]    cnt_addr;
   logic [ADDR_BITS-1:0]   start_rdata;
   logic [COUNT_BITS-1:0]  cnt_rdata;
   logic [COUNT_BITS-1:0]  cnt_value;
   logic [COUNT_BITS-1:0]  cnt_next;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
         enable_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRIES: entries_ff <= csr_wdata;
            CSR_ENABLE:  enable_ff  <= csr_wdata[0];
            default:     enable_ff  <= enable_ff;
         endcase
      end
   end

   // captured transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= action_type'(req_tuser);
         idx_ff    <= req_tdata[ENTRY_BITS-1:0];
         addr_ff   <= req_tdata[ENTRY_BITS +: ADDR_BITS];
      end
   end

   // search bounds
   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = bound_sum[IDX_BITS:1];
   assign region    = IDX_BITS'(lo_ff - PTR_BITS'(1));
   assign cnt_addr  = (action_ff == ACT_READ) ? IDX_BITS'(idx_ff) : region;

   always_comb begin
      if (32'(entries_ff) > 32'(MAX_ENTRIES)) begin
         limit = PTR_BITS'(MAX_ENTRIES);
      end else begin
         limit = PTR_BITS'(entries_ff);
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = limit;
      end else if (cmd.probe_step) begin
         if (start_rdata <= addr_ff) begin
            lo_in = {1'b0, mid} + PTR_BITS'(1);
         end else begin
            hi_in = {1'b0, mid};
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   pshp_ram #(
      .WIDTH (ADDR_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_starts (
      .clock   (clock),
      .wr_en   (cmd.start_wr),
      .wr_addr (IDX_BITS'(idx_ff)),
      .wr_data (addr_ff),
      .rd_addr (mid),
      .rd_data (start_rdata)
   );

   // bin counters
   assign cnt_value = valid_ff[cnt_addr] ? cnt_rdata : '0;
   assign cnt_next  = sat_inc(cnt_value);

   pshp_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_counts (
      .clock   (clock),
      .wr_en   (cmd.count_update),
      .wr_addr (cnt_addr),
      .wr_data (cnt_next),
      .rd_addr (cnt_addr),
      .rd_data (cnt_rdata)
   );

   always_comb begin
      valid_in = valid_ff;
      total_in = total_ff;
      if (cmd.clear) begin
         valid_in = '0;
         total_in = '0;
      end else begin
         if (cmd.count_update) begin
            valid_in[cnt_addr] = 1'b1;
         end
         if (cmd.total_inc) begin
            total_in = sat_inc(total_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         total_ff <= total_in;
      end
   end

   // per transaction result fields
   always_comb begin
      found_in = found_ff;
      count_in = count_ff;
      if (cmd.capture) begin
         found_in = 1'b0;
         count_in = '0;
      end else if (cmd.count_update) begin
         found_in = 1'b1;
         count_in = cnt_next;
      end else if (cmd.count_take) begin
         count_in = cnt_value;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      count_ff <= count_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (found_ff) begin
            out_index_ff <= ENTRY_BITS'(region);
         end else if (action_ff == ACT_READ) begin
            out_index_ff <= idx_ff;
         end else begin
            out_index_ff <= '0;
         end
         out_found_ff <= found_ff;
         out_count_ff <= count_ff;
         out_total_ff <= total_ff;
      end
   end

   assign status.action     = action_ff;
   assign status.enabled    = enable_ff;
   assign status.lo_lt_hi   = lo_ff < hi_ff;
   assign status.lo_nonzero = lo_ff != '0;

   assign rsp_tdata = {out_total_ff, out_count_ff, out_index_ff};
   assign rsp_tuser = out_found_ff;

endmodule

// ===== rtl/pc_sample_histogram_profiler_unit.sv =====
// ----------------------------------------------------------------------------
// pc_sample_histogram_profiler_unit
// Program counter sampling profiler: region start table, binary search and
// saturating per region and total sample counters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req      | in        | req_tvalid/req_tready | tuser action, tdata index/address
//  rsp      | out       | rsp_tvalid/rsp_tready | tuser found, tdata index/count/total
//  csr      | in        | csr_we                | csr_index, csr_wdata
//
// one transaction at a time; an enabled sample runs a binary search in which
// each probe is a registered table read, then a compare.
// synchronous active high reset; clear empties all bins at once.
// a finished result waits in the output register while the next
// transaction is accepted and searched; a stalled rsp holds only the finish.
// ----------------------------------------------------------------------------
module pc_sample_histogram_profiler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pshp_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // entry_index, address
   input  logic [pshp_pkg::ACTION_BITS-1:0]    req_tuser,  // action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pshp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // region_index, bin_count,
                                                           // total_samples
   output logic                                rsp_tuser,  // region_found
   input  logic                                csr_we,
   input  logic [pshp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pshp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import pshp_pkg::*;

   cmd_type    cmd;
   status_type status;

   pshp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pshp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
